### rtl/swm_pkg.sv
// swm_pkg: shared constants and types for the sliding window maximum unit.
// No dependencies; imported by swm_cell and sliding_window_maximum_unit.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int CFG_W        = 7;
    localparam int AGE_W        = 7;
    localparam int CNT_W        = $clog2(WINDOW_MAX + 1);

    localparam logic [AGE_W-1:0] AGE_LIMIT  = {AGE_W{1'b1}};
    localparam logic [CFG_W-1:0] WIN_RESET  = CFG_W'(3);
    localparam logic [CFG_W-1:0] WIN_LIMIT  = CFG_W'(WINDOW_MAX);
    localparam logic [CNT_W-1:0] SEEN_LIMIT = CNT_W'(WINDOW_MAX);

    // What a cell shows its neighbors for the current transaction.
    typedef struct packed {
        logic                    live;   // valid after a first-of-stream clear
        logic                    keep;   // survives the pop against the new sample
        logic [SAMPLE_WIDTH-1:0] value;
        logic [AGE_W-1:0]        age;    // already aged by one sample
    } t_swm_link;

endpackage

### rtl/swm_cell.sv
// swm_cell: one entry of the monotonic candidate queue (value, age, valid).
// Depends on swm_pkg for widths and the t_swm_link neighbor struct.
`timescale 1ns / 1ps

module swm_cell
    import swm_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_clear,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic                           i_shift,
    input  logic                           i_prev_keep,  // slot ahead keeps its entry
    input  t_swm_link                      i_nbr,
    output t_swm_link                      o_link,
    output logic [SAMPLE_WIDTH-1:0]        o_next_value
);

    logic [SAMPLE_WIDTH-1:0] r_value, n_value;
    logic [AGE_W-1:0]        r_age, n_age;
    logic                    r_valid, n_valid;
    logic [AGE_W-1:0]        age_inc;
    logic                    live, keep;
    t_swm_link               src;

    assign age_inc = (r_age == AGE_LIMIT) ? r_age : r_age + AGE_W'(1);
    assign live    = r_valid & ~i_clear;
    assign keep    = live & ($signed(r_value) > i_x);

    assign o_link = '{live: live, keep: keep, value: r_value, age: age_inc};

    // On a front shift this cell takes its right neighbor's entry.
    assign src = i_shift ? i_nbr : o_link;

    always_comb begin
        if (src.keep) begin
            n_value = src.value;
            n_age   = src.age;
            n_valid = 1'b1;
        end else if (i_prev_keep) begin
            // first free slot: the new sample lands here
            n_value = i_x;
            n_age   = '0;
            n_valid = 1'b1;
        end else begin
            n_value = r_value;
            n_age   = r_age;
            n_valid = 1'b0;
        end
    end

    assign o_next_value = n_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
        end else if (i_accept) begin
            r_valid <= n_valid;
            r_age   <= n_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_value <= n_value;
        end
    end

endmodule

### rtl/sliding_window_maximum_unit.sv
// sliding_window_maximum_unit: running maximum over the last window_size samples.
// Depends on swm_pkg and a chain of WINDOW_MAX swm_cell instances.
`timescale 1ns / 1ps

//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  input    | i_in_valid / o_in_stall    | i_sample_value, i_first_of_stream
//  output   | o_out_valid / i_out_stall  | o_window_max
//  config   | i_cfg_we                   | i_cfg_wdata (window_size)
//
// One sample is taken per cycle unless o_in_stall is high; every cell of the chain
// compares, ages and shifts in the same cycle, so the whole queue updates together.
// The result is registered and appears in the cycle after the sample transaction.
// A held result blocks a new sample only while i_out_stall is high.
// Reset empties the queue, clears the sample count and sets window_size to 3.
// No result is produced until window_size samples have been seen in the stream.

module sliding_window_maximum_unit
    import swm_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_value,
    input  logic                           i_first_of_stream,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_window_max,
    input  logic                           i_cfg_we,
    input  logic [CFG_W-1:0]               i_cfg_wdata
);

    logic [CFG_W-1:0]        r_window;
    logic [CNT_W-1:0]        r_seen, n_seen, seen_base;
    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_data;

    logic [CFG_W-1:0]        win_k;
    logic                    accept, drop, shift, produce;

    t_swm_link               links [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0] next_vals [WINDOW_MAX];

    // window size clamped to 1..WINDOW_MAX
    always_comb begin
        if (r_window == '0) begin
            win_k = CFG_W'(1);
        end else if (r_window > WIN_LIMIT) begin
            win_k = WIN_LIMIT;
        end else begin
            win_k = r_window;
        end
    end

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    // Front expires once its age reaches the window; a full queue also shifts.
    assign drop  = links[0].live & ({{(CFG_W - AGE_W + 1){1'b0}}, links[0].age}
                   >= {1'b0, win_k});
    assign shift = drop | links[WINDOW_MAX-1].keep;

    genvar j;
    generate
        for (j = 0; j < WINDOW_MAX; j++) begin : g_cell
            logic      prev_keep;
            t_swm_link nbr;

            if (j == 0) begin : g_head
                assign prev_keep = 1'b1;
            end else begin : g_body
                // after a front shift the slot ahead holds the entry from this cell
                assign prev_keep = shift ? links[j].keep : links[j-1].keep;
            end

            if (j == WINDOW_MAX - 1) begin : g_tail
                assign nbr = '0;
            end else begin : g_inner
                assign nbr = links[j+1];
            end

            swm_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_accept     (accept),
                .i_clear      (i_first_of_stream),
                .i_x          (i_sample_value),
                .i_shift      (shift),
                .i_prev_keep  (prev_keep),
                .i_nbr        (nbr),
                .o_link       (links[j]),
                .o_next_value (next_vals[j])
            );
        end
    endgenerate

    // Sample count, saturating at WINDOW_MAX and restarted by first-of-stream.
    assign seen_base = i_first_of_stream ? '0 : r_seen;
    assign n_seen    = (seen_base < SEEN_LIMIT) ? seen_base + CNT_W'(1) : seen_base;
    assign produce   = ({{(CFG_W - CNT_W + 1){1'b0}}, n_seen} >= {1'b0, win_k});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WIN_RESET;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (accept) begin
                r_seen      <= n_seen;
                r_out_valid <= produce;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // front of the updated queue is the window maximum
    always_ff @(posedge i_clk) begin
        if (accept && produce) begin
            r_out_data <= next_vals[0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_max = $signed(r_out_data);

endmodule
